/* sv/websocket_frame_encoder_unit_macros.svh */
// Assertion macros for the frame encoder checker.
`ifndef WEBSOCKET_FRAME_ENCODER_UNIT_MACROS_SVH
`define WEBSOCKET_FRAME_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define WSFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define WSFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/wsfe_pkg.sv */
// Types, constants and byte helpers for the WebSocket frame encoder.
package wsfe_pkg;

	localparam int LEN_W  = 31;
	localparam int KEY_W  = 32;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 4;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_DATA  = 1'b1;

	localparam logic [BYTE_W-1:0] HDR_BIN_FIN = 8'h82;
	localparam logic [LEN_W-1:0]  LEN_SHORT_MAX = 31'd125;
	localparam logic [LEN_W-1:0]  LEN_MID_MAX   = 31'd65535;
	localparam logic [6:0]        LEN_CODE_16   = 7'd126;
	localparam logic [6:0]        LEN_CODE_64   = 7'd127;

	localparam logic [IDX_W-1:0] EXT_NONE = 4'd0;
	localparam logic [IDX_W-1:0] EXT_16   = 4'd2;
	localparam logic [IDX_W-1:0] EXT_64   = 4'd8;
	localparam logic [IDX_W-1:0] KEY_BYTES = 4'd4;
	localparam logic [IDX_W-1:0] BASE_BYTES = 4'd2;

	typedef struct packed {
		logic              func;
		logic [LEN_W-1:0]  payload_length;
		logic              mask_enable;
		logic [KEY_W-1:0]  masking_key;
		logic [BYTE_W-1:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              frame_end;
	} res_t;

	typedef struct packed {
		logic load;
		res_t res;
	} emit_t;

	// key byte 0 is the most significant
	function automatic logic [BYTE_W-1:0] key_byte(input logic [KEY_W-1:0] key,
			input logic [1:0] phase);
		logic [BYTE_W-1:0] b;
		case (phase)
			2'd0: b = key[31:24];
			2'd1: b = key[23:16];
			2'd2: b = key[15:8];
			2'd3: b = key[7:0];
			default: b = key[7:0];
		endcase
		return b;
	endfunction

	// byte k (0 = least significant) of the length zero-extended to 64 bits
	function automatic logic [BYTE_W-1:0] len_byte(input logic [LEN_W-1:0] len,
			input logic [2:0] k);
		logic [63:0] l64;
		l64 = {33'd0, len};
		return l64[{k, 3'b000} +: BYTE_W];
	endfunction

endpackage

/* sv/wsfe_in_reg.sv */
// Input register holding the transaction under work.
module wsfe_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  wsfe_pkg::item_t in_item,
	input  logic            take,
	output logic            valid_s1,
	output wsfe_pkg::item_t item_s1
);

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

/* sv/wsfe_encoder.sv */
// Frame state and byte selection: header sequencing and payload masking.
module wsfe_encoder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  wsfe_pkg::item_t item_s1,
	input  logic            out_ready,
	output logic            take,
	output wsfe_pkg::emit_t emit
);

	logic [wsfe_pkg::LEN_W-1:0] rem_q;
	logic                       mask_q;
	logic [wsfe_pkg::KEY_W-1:0] key_q;
	logic [1:0]                 phase_q;
	logic [wsfe_pkg::IDX_W-1:0] idx_q;

	logic                        is_start;
	logic [wsfe_pkg::LEN_W-1:0]  len;
	logic [wsfe_pkg::IDX_W-1:0]  ext_cnt;
	logic [wsfe_pkg::IDX_W-1:0]  hdr_n;
	logic [wsfe_pkg::IDX_W-1:0]  j;
	logic [wsfe_pkg::IDX_W-1:0]  k_ext;
	logic [wsfe_pkg::IDX_W-1:0]  k_key;
	logic [6:0]                  len_code;
	logic                        hdr_last;
	logic                        rem_zero;
	logic                        gen_valid;
	logic [wsfe_pkg::BYTE_W-1:0] hdr_byte;
	logic [wsfe_pkg::BYTE_W-1:0] data_out;

	assign is_start = (item_s1.func == wsfe_pkg::FUNC_START);
	assign len      = item_s1.payload_length;
	assign rem_zero = (rem_q == '0);

	always_comb begin
		if (len > wsfe_pkg::LEN_MID_MAX) begin
			ext_cnt  = wsfe_pkg::EXT_64;
			len_code = wsfe_pkg::LEN_CODE_64;
		end else if (len > wsfe_pkg::LEN_SHORT_MAX) begin
			ext_cnt  = wsfe_pkg::EXT_16;
			len_code = wsfe_pkg::LEN_CODE_16;
		end else begin
			ext_cnt  = wsfe_pkg::EXT_NONE;
			len_code = len[6:0];
		end
	end

	assign hdr_n = wsfe_pkg::BASE_BYTES + ext_cnt
		+ (item_s1.mask_enable ? wsfe_pkg::KEY_BYTES : '0);
	assign hdr_last = (idx_q == hdr_n - 4'd1);
	assign j        = idx_q - wsfe_pkg::BASE_BYTES;
	assign k_ext    = ext_cnt - 4'd1 - j;
	assign k_key    = j - ext_cnt;

	always_comb begin
		if (idx_q == 4'd0) begin
			hdr_byte = wsfe_pkg::HDR_BIN_FIN;
		end else if (idx_q == 4'd1) begin
			hdr_byte = {item_s1.mask_enable, len_code};
		end else if (j < ext_cnt) begin
			hdr_byte = wsfe_pkg::len_byte(len, k_ext[2:0]);
		end else begin
			hdr_byte = wsfe_pkg::key_byte(item_s1.masking_key, k_key[1:0]);
		end
	end

	assign data_out = item_s1.data_byte
		^ (mask_q ? wsfe_pkg::key_byte(key_q, phase_q) : '0);

	assign gen_valid = valid_s1 && (is_start || !rem_zero);
	assign take = valid_s1 && (is_start ? (out_ready && hdr_last)
		: (rem_zero || out_ready));

	always_comb begin
		emit.load = gen_valid && out_ready;
		if (is_start) begin
			emit.res.out_byte  = hdr_byte;
			emit.res.run_last  = hdr_last;
			emit.res.frame_end = hdr_last && (len == '0);
		end else begin
			emit.res.out_byte  = data_out;
			emit.res.run_last  = 1'b1;
			emit.res.frame_end = (rem_q == 31'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			mask_q  <= 1'b0;
			key_q   <= '0;
			phase_q <= '0;
			idx_q   <= '0;
		end else if (emit.load) begin
			if (is_start) begin
				idx_q <= hdr_last ? '0 : idx_q + 4'd1;
				if (hdr_last) begin
					rem_q   <= len;
					mask_q  <= item_s1.mask_enable;
					key_q   <= item_s1.masking_key;
					phase_q <= '0;
				end
			end else begin
				rem_q   <= rem_q - 31'd1;
				phase_q <= phase_q + 2'd1;
			end
		end
	end

endmodule

/* sv/wsfe_out_reg.sv */
// Output register for encoded bytes.
module wsfe_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  wsfe_pkg::emit_t emit,
	output logic            out_ready,
	output logic            out_valid,
	input  logic            out_stall,
	output wsfe_pkg::res_t  res_q
);

	assign out_ready = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= emit.load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && emit.load) begin
			res_q <= emit.res;
		end
	end

endmodule

/* sv/websocket_frame_encoder_unit.sv */
// Top level of the WebSocket binary frame encoder.
// channel | handshake           | payload
// in      | in_valid, in_stall  | func, payload_length, mask_enable, masking_key, data_byte
// out     | out_valid, out_stall| out_byte, run_last, frame_end
// A payload transaction produces its byte through the input and output registers, one per cycle while out_stall is low.
// A start transaction produces 2 to 14 header bytes, one per cycle from the header
// sequencer while the output is not stalled; the next transaction is accepted in the cycle the last one is loaded.
// A payload byte with nothing remaining is dropped with no output.
// Reset clears the frame state and both valid flags; out_stall holds the output
// register and backs up to in_stall in the same cycle.
module websocket_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [30:0] payload_length,
	input  logic        mask_enable,
	input  logic [31:0] masking_key,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        frame_end
);

	wsfe_pkg::item_t in_item;
	wsfe_pkg::item_t item_s1;
	wsfe_pkg::emit_t emit;
	wsfe_pkg::res_t  res_q;
	logic            valid_s1;
	logic            take;
	logic            out_ready;

	assign in_item = '{func: func, payload_length: payload_length,
		mask_enable: mask_enable, masking_key: masking_key, data_byte: data_byte};

	wsfe_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wsfe_encoder u_enc (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.out_ready (out_ready),
		.take      (take),
		.emit      (emit)
	);

	wsfe_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign out_byte  = res_q.out_byte;
	assign run_last  = res_q.run_last;
	assign frame_end = res_q.frame_end;

endmodule

/* sv/wsfe_checker.sv */
// Port-level checker for the frame encoder, bound to the top level.
`include "websocket_frame_encoder_unit_macros.svh"

module wsfe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        run_last,
	input logic        frame_end
);

	// held output transaction keeps its payload
	`WSFE_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last) && $stable(frame_end), "output changed while stalled")

	// end of frame is always the last byte of its transaction
	`WSFE_ASSERT_NOW(a_end_is_last, clk, arst_n, out_valid && frame_end, run_last, "frame_end without run_last")

	// header bytes stream without gaps
	`WSFE_ASSERT_NEXT(a_hdr_gapless, clk, arst_n, out_valid && !out_stall && !run_last, out_valid, "gap inside header")

	// a stalled input with an empty output must produce a byte next
	`WSFE_ASSERT_NEXT(a_stall_progress, clk, arst_n, in_stall && !out_valid, out_valid, "input stalled with no output")

endmodule

bind websocket_frame_encoder_unit wsfe_checker u_wsfe_checker (.*);
